### sv/bpte_pkg.sv
// Shared types, constants and the coefficient build program of the trajectory evaluator.
`timescale 1ns / 1ps
`default_nettype none
package bpte_pkg;

    // Fixed-point formats
    localparam int VALUE_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS  = 40;
    localparam int TIME_FRAC_BITS  = 16;
    localparam int OUT_SHIFT       = COEF_FRAC_BITS - VALUE_FRAC_BITS;

    localparam int NUM_LANES = 4;   // position, velocity, acceleration, jerk
    localparam int NUM_CELLS = 5;   // Horner steps of the longest lane
    localparam int CACHE_N   = 18;  // scaled coefficients of all lanes

    typedef logic signed [63:0] t_word;

    // Configuration register indexes
    localparam logic [2:0] CFG_FIT_MODE   = 3'd0;
    localparam logic [2:0] CFG_START_POS  = 3'd1;
    localparam logic [2:0] CFG_START_VEL  = 3'd2;
    localparam logic [2:0] CFG_START_ACC  = 3'd3;
    localparam logic [2:0] CFG_END_POS    = 3'd4;
    localparam logic [2:0] CFG_END_VEL    = 3'd5;
    localparam logic [2:0] CFG_END_ACC    = 3'd6;
    localparam logic [2:0] CFG_DURATION   = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Builder operations
    typedef enum logic [2:0] {
        OP_MOV = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_BRQ = 3'd5,
        OP_JMP = 3'd6,
        OP_END = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        B_REG = 2'd0,
        B_IMM = 2'd1,
        B_CFG = 2'd2
    } t_bsel;

    typedef struct packed {
        t_op               op;
        logic [3:0]        dst;
        logic [3:0]        a;
        t_bsel             bsel;
        logic [3:0]        b;
        logic signed [7:0] imm;
        logic [5:0]        sh;
        logic              cwr;
        logic [4:0]        cidx;
    } t_instr;

    // Builder status seen by the evaluation pipeline
    typedef struct packed {
        logic valid;
        logic sat;
        logic dur_zero;
    } t_build_st;

    // Data moving along the row of cells
    typedef struct packed {
        logic             valid;
        logic             dz;
        logic             ovf;
        logic [23:0]      s;
        t_word [3:0]      acc;
    } t_lane_bus;

    // First cache slot of each derivative lane
    function automatic int lane_base(input int d);
        int r;
        case (d)
            0: r = 0;
            1: r = 6;
            2: r = 11;
            default: r = 15;
        endcase
        return r;
    endfunction

    // Cache slot of coefficient m in lane d
    function automatic int cache_idx(input int d, input int m);
        int r;
        r = (m >= d) ? lane_base(d) + m - d : 0;
        return r;
    endfunction

    function automatic t_instr mk(input t_op op, input int dst, input int a, input t_bsel bs,
                                  input int b, input int imm, input int sh, input bit cwr,
                                  input int cidx);
        t_instr r;
        r.op   = op;
        r.dst  = 4'(dst);
        r.a    = 4'(a);
        r.bsel = bs;
        r.b    = 4'(b);
        r.imm  = 8'(imm);
        r.sh   = 6'(sh);
        r.cwr  = cwr;
        r.cidx = 5'(cidx);
        return r;
    endfunction

    function automatic t_instr i_mov(input int dst, input int idx);
        return mk(OP_MOV, dst, 0, B_CFG, 0, idx, 0, 1'b0, 0);
    endfunction

    function automatic t_instr i_alu(input t_op op, input int dst, input int a, input int b);
        return mk(op, dst, a, B_REG, b, 0, 0, 1'b0, 0);
    endfunction

    function automatic t_instr i_mul(input int dst, input int a, input int b, input int sh);
        return mk(OP_MUL, dst, a, B_REG, b, 0, sh, 1'b0, 0);
    endfunction

    function automatic t_instr i_mulk(input int dst, input int a, input int imm, input int sh);
        return mk(OP_MUL, dst, a, B_IMM, 0, imm, sh, 1'b0, 0);
    endfunction

    // divide in place by the duration
    function automatic t_instr i_div(input int dst);
        return mk(OP_DIV, dst, dst, B_REG, 6, 0, COEF_FRAC_BITS, 1'b0, 0);
    endfunction

    // scale a coefficient into a cache slot
    function automatic t_instr i_cw(input int a, input int imm, input int cidx);
        return mk(OP_MUL, 12, a, B_IMM, 0, imm, 0, 1'b1, cidx);
    endfunction

    // Build program. R0..R5 boundary values, R6 duration, R11 c2, R15 c3, R3 c4, R4 c5.
    function automatic t_instr prog_rom(input logic [6:0] pc);
        t_instr r;
        case (pc)
            7'd0:  r = i_mov(0, 0);
            7'd1:  r = i_mov(1, 1);
            7'd2:  r = i_mov(2, 2);
            7'd3:  r = i_mov(3, 3);
            7'd4:  r = i_mov(4, 4);
            7'd5:  r = i_mov(5, 5);
            7'd6:  r = i_mov(6, 6);
            7'd7:  r = i_mul(7, 6, 6, COEF_FRAC_BITS);
            7'd8:  r = i_mul(8, 2, 6, COEF_FRAC_BITS);
            7'd9:  r = i_alu(OP_SUB, 9, 4, 1);
            7'd10: r = i_alu(OP_SUB, 9, 9, 8);
            7'd11: r = i_alu(OP_SUB, 10, 5, 2);
            7'd12: r = i_mulk(11, 2, 1, 1);
            7'd13: r = mk(OP_BRQ, 0, 0, B_IMM, 0, 47, 0, 1'b0, 0);
            // quintic: h, dv*T, da*T^2
            7'd14: r = i_alu(OP_SUB, 8, 3, 0);
            7'd15: r = i_mul(12, 1, 6, COEF_FRAC_BITS);
            7'd16: r = i_alu(OP_SUB, 8, 8, 12);
            7'd17: r = i_mul(12, 2, 7, COEF_FRAC_BITS + 1);
            7'd18: r = i_alu(OP_SUB, 8, 8, 12);
            7'd19: r = i_mul(12, 9, 6, COEF_FRAC_BITS);
            7'd20: r = i_mul(13, 10, 7, COEF_FRAC_BITS);
            7'd21: r = i_mul(14, 10, 7, COEF_FRAC_BITS + 1);
            // c3
            7'd22: r = i_mulk(15, 8, 10, 0);
            7'd23: r = i_mulk(3, 12, 4, 0);
            7'd24: r = i_alu(OP_SUB, 15, 15, 3);
            7'd25: r = i_alu(OP_ADD, 15, 15, 14);
            7'd26, 7'd27, 7'd28: r = i_div(15);
            // c4
            7'd29: r = i_mulk(3, 8, -15, 0);
            7'd30: r = i_mulk(4, 12, 7, 0);
            7'd31: r = i_alu(OP_ADD, 3, 3, 4);
            7'd32: r = i_alu(OP_SUB, 3, 3, 13);
            7'd33, 7'd34, 7'd35, 7'd36: r = i_div(3);
            // c5
            7'd37: r = i_mulk(4, 8, 6, 0);
            7'd38: r = i_mulk(5, 12, 3, 0);
            7'd39: r = i_alu(OP_SUB, 4, 4, 5);
            7'd40: r = i_alu(OP_ADD, 4, 4, 14);
            7'd41, 7'd42, 7'd43, 7'd44, 7'd45: r = i_div(4);
            7'd46: r = mk(OP_JMP, 0, 0, B_IMM, 0, 60, 0, 1'b0, 0);
            // quartic
            7'd47: r = i_mul(8, 10, 6, COEF_FRAC_BITS);
            7'd48: r = i_mulk(12, 9, 2, 0);
            7'd49: r = i_alu(OP_SUB, 13, 8, 12);
            7'd50: r = i_mulk(12, 9, 3, 0);
            7'd51: r = i_alu(OP_SUB, 14, 12, 8);
            7'd52, 7'd53, 7'd54: r = i_div(13);
            7'd55: r = i_mulk(3, 13, 1, 2);
            7'd56, 7'd57: r = i_div(14);
            7'd58: r = mk(OP_DIV, 15, 14, B_IMM, 0, 3, 0, 1'b0, 0);
            7'd59: r = mk(OP_MOV, 4, 0, B_IMM, 0, 0, 0, 1'b0, 0);
            // scaled coefficients per derivative lane
            7'd60: r = i_cw(0, 1, 0);
            7'd61: r = i_cw(1, 1, 1);
            7'd62: r = i_cw(11, 1, 2);
            7'd63: r = i_cw(15, 1, 3);
            7'd64: r = i_cw(3, 1, 4);
            7'd65: r = i_cw(4, 1, 5);
            7'd66: r = i_cw(1, 1, 6);
            7'd67: r = i_cw(11, 2, 7);
            7'd68: r = i_cw(15, 3, 8);
            7'd69: r = i_cw(3, 4, 9);
            7'd70: r = i_cw(4, 5, 10);
            7'd71: r = i_cw(11, 2, 11);
            7'd72: r = i_cw(15, 6, 12);
            7'd73: r = i_cw(3, 12, 13);
            7'd74: r = i_cw(4, 20, 14);
            7'd75: r = i_cw(15, 6, 15);
            7'd76: r = i_cw(3, 24, 16);
            7'd77: r = i_cw(4, 60, 17);
            default: r = mk(OP_END, 0, 0, B_REG, 0, 0, 0, 1'b0, 0);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/bpte_intf.sv
// Channel interfaces: sample input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface bpte_sample_if;
    logic        valid;
    logic        ready;
    logic [23:0] sample_time;
    modport source(output valid, output sample_time, input ready);
    modport sink(input valid, input sample_time, output ready);
endinterface

interface bpte_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic signed [31:0] accel_out;
    logic signed [31:0] jerk_out;
    logic [1:0]         status;
    modport source(output valid, output position_out, output velocity_out,
                   output accel_out, output jerk_out, output status, input ready);
    modport sink(input valid, input position_out, input velocity_out,
                 input accel_out, input jerk_out, input status, output ready);
endinterface

interface bpte_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/bpte_builder.sv
// Configuration registers and the sequenced coefficient builder (shared multiplier and divider).
`timescale 1ns / 1ps
`default_nettype none
module bpte_builder (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    bpte_cfg_if.sink                         i_cfg,
    output bpte_pkg::t_build_st              o_st,
    output bpte_pkg::t_word [bpte_pkg::CACHE_N-1:0] o_cache
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_MFIN  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_DFIN  = 8'b0100_0000,
        S_WB    = 8'b1000_0000
    } t_state;

    // configuration registers
    logic               r_mode;
    logic signed [31:0] r_cfgv [6];
    logic [23:0]        r_dur;

    // sequencer state
    t_state             r_state;
    logic [6:0]         r_pc;
    logic               r_valid;
    logic               r_sat;
    logic               r_ovf;

    // datapath
    bpte_pkg::t_word    r_rf [16];
    bpte_pkg::t_word    r_opa;
    bpte_pkg::t_word    r_opb;
    bpte_pkg::t_word    r_cache [bpte_pkg::CACHE_N];
    logic [63:0]        r_ma;
    logic [63:0]        r_mb;
    logic               r_neg;
    logic [1:0]         r_mcnt;
    logic signed [127:0] r_prod;
    logic [5:0]         r_shift;
    logic [127:0]       r_num;
    logic [127:0]       r_q;
    logic [63:0]        r_rem;
    logic [63:0]        r_den;
    logic [6:0]         r_dcnt;

    bpte_pkg::t_instr   instr;
    bpte_pkg::t_word    cfg_word;
    bpte_pkg::t_word    bval;
    logic [63:0]        mag_a;
    logic [63:0]        mag_b;
    logic signed [64:0] sum65;
    logic [63:0]        pp;
    logic [1:0]         pp_pos;
    logic [64:0]        rem2;
    logic               q_bit;
    logic signed [127:0] wb_shifted;
    bpte_pkg::t_word    wb_res;
    logic               wb_sat;
    logic               cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            for (int i = 0; i < 6; i++) r_cfgv[i] <= '0;
            r_dur  <= 24'd65536;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                bpte_pkg::CFG_FIT_MODE:  r_mode    <= i_cfg.data[0];
                bpte_pkg::CFG_START_POS: r_cfgv[0] <= i_cfg.data;
                bpte_pkg::CFG_START_VEL: r_cfgv[1] <= i_cfg.data;
                bpte_pkg::CFG_START_ACC: r_cfgv[2] <= i_cfg.data;
                bpte_pkg::CFG_END_POS:   r_cfgv[3] <= i_cfg.data;
                bpte_pkg::CFG_END_VEL:   r_cfgv[4] <= i_cfg.data;
                bpte_pkg::CFG_END_ACC:   r_cfgv[5] <= i_cfg.data;
                bpte_pkg::CFG_DURATION:  r_dur     <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    // operand selection and the combinational parts of each operation
    always_comb begin
        instr = bpte_pkg::prog_rom(r_pc);
        case (instr.imm[2:0])
            3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5:
                cfg_word = {{8{r_cfgv[instr.imm[2:0]][31]}}, r_cfgv[instr.imm[2:0]], 24'b0};
            default: cfg_word = {16'b0, r_dur, 24'b0};
        endcase
        case (instr.bsel)
            bpte_pkg::B_REG: bval = r_opb;
            bpte_pkg::B_IMM: bval = 64'(instr.imm);
            default:         bval = cfg_word;
        endcase
        mag_a = r_opa[63] ? 64'(-r_opa) : r_opa;
        mag_b = bval[63] ? 64'(-bval) : bval;
        if (instr.op == bpte_pkg::OP_SUB) begin
            sum65 = 65'(r_opa) - 65'(bval);
        end else begin
            sum65 = 65'(r_opa) + 65'(bval);
        end
        // one 32x32 partial product per cycle
        pp     = 64'(r_ma[{r_mcnt[0], 5'b0} +: 32]) * 64'(r_mb[{r_mcnt[1], 5'b0} +: 32]);
        pp_pos = {1'b0, r_mcnt[0]} + {1'b0, r_mcnt[1]};
        // one restoring division step
        rem2   = {r_rem, r_num[127]};
        q_bit  = r_rem[63] || (rem2[63:0] >= r_den);
        // round/shift result and saturate to 64 bits
        wb_shifted = r_prod >>> r_shift;
        wb_sat     = (wb_shifted[127:63] != {65{wb_shifted[63]}});
        if (!wb_sat) begin
            wb_res = wb_shifted[63:0];
        end else if (wb_shifted[127]) begin
            wb_res = {1'b1, 63'b0};
        end else begin
            wb_res = {1'b0, {63{1'b1}}};
        end
    end

    // register file and coefficient cache
    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_opa <= r_rf[instr.a];
            r_opb <= r_rf[instr.b];
        end
        if (r_state == S_WB) begin
            r_rf[instr.dst] <= wb_res;
            if (instr.cwr) r_cache[instr.cidx] <= wb_res;
        end
    end

    // arithmetic unit registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_EXEC: begin
                case (instr.op)
                    bpte_pkg::OP_MOV: begin
                        r_prod  <= 128'(bval);
                        r_shift <= '0;
                    end
                    bpte_pkg::OP_ADD, bpte_pkg::OP_SUB: begin
                        r_prod  <= 128'(sum65);
                        r_shift <= '0;
                    end
                    bpte_pkg::OP_MUL: begin
                        r_ma    <= mag_a;
                        r_mb    <= mag_b;
                        r_neg   <= r_opa[63] ^ bval[63];
                        r_prod  <= '0;
                        r_mcnt  <= '0;
                        r_shift <= instr.sh;
                    end
                    bpte_pkg::OP_DIV: begin
                        r_num   <= (128'(mag_a) << instr.sh) + 128'(bval[63:1]);
                        r_den   <= bval;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_dcnt  <= '0;
                        r_neg   <= r_opa[63];
                        r_prod  <= '0;
                        r_shift <= '0;
                    end
                    default: ;
                endcase
            end
            S_MUL: begin
                r_prod <= r_prod + $signed(128'(pp) << {pp_pos, 5'b0});
                r_mcnt <= r_mcnt + 2'd1;
            end
            S_MFIN: begin
                if (r_shift != '0) begin
                    r_prod <= (r_neg ? -r_prod : r_prod) + $signed(128'(1) << (r_shift - 6'd1));
                end else begin
                    r_prod <= r_neg ? -r_prod : r_prod;
                end
            end
            S_DIV: begin
                r_rem  <= q_bit ? (rem2[63:0] - r_den) : rem2[63:0];
                r_q    <= {r_q[126:0], q_bit};
                r_num  <= {r_num[126:0], 1'b0};
                r_dcnt <= r_dcnt + 7'd1;
            end
            S_DFIN: begin
                r_prod <= r_neg ? -$signed(r_q) : $signed(r_q);
            end
            default: ;
        endcase
    end

    // build sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_valid <= 1'b0;
            r_sat   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (cfg_wr) begin
            // any write drops the cache and restarts the build
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!r_valid && r_dur != '0) begin
                        r_pc    <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_EXEC;
                S_EXEC: begin
                    case (instr.op)
                        bpte_pkg::OP_MUL: r_state <= S_MUL;
                        bpte_pkg::OP_DIV: begin
                            if (bval == '0) begin
                                r_ovf   <= 1'b1;
                                r_state <= S_WB;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        bpte_pkg::OP_BRQ: begin
                            r_pc    <= r_mode ? instr.imm[6:0] : r_pc + 7'd1;
                            r_state <= S_FETCH;
                        end
                        bpte_pkg::OP_JMP: begin
                            r_pc    <= instr.imm[6:0];
                            r_state <= S_FETCH;
                        end
                        bpte_pkg::OP_END: begin
                            r_valid <= 1'b1;
                            r_sat   <= r_ovf;
                            r_state <= S_IDLE;
                        end
                        default: r_state <= S_WB;
                    endcase
                end
                S_MUL:  if (r_mcnt == 2'd3) r_state <= S_MFIN;
                S_MFIN: r_state <= S_WB;
                S_DIV:  if (r_dcnt == 7'd127) r_state <= S_DFIN;
                S_DFIN: r_state <= S_WB;
                S_WB: begin
                    r_ovf   <= r_ovf | wb_sat;
                    r_pc    <= r_pc + 7'd1;
                    r_state <= S_FETCH;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_st.valid    = r_valid;
    assign o_st.sat      = r_sat;
    assign o_st.dur_zero = (r_dur == '0);

    always_comb begin
        for (int i = 0; i < bpte_pkg::CACHE_N; i++) o_cache[i] = r_cache[i];
    end

endmodule
`default_nettype wire

### sv/bpte_cell.sv
// One Horner cell: acc = sat(acc * t + k) for each active derivative lane, two stages.
`timescale 1ns / 1ps
`default_nettype none
module bpte_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire [3:0]                    i_active,
    input  wire bpte_pkg::t_word [3:0]   i_k,
    input  wire bpte_pkg::t_lane_bus     i_bus,
    output bpte_pkg::t_lane_bus          o_bus
);

    // stage A: partial products
    logic                r_va;
    logic                r_dza;
    logic                r_ovfa;
    logic [23:0]         r_sa;
    bpte_pkg::t_word     r_acca [4];
    logic [55:0]         r_lo [4];
    logic signed [56:0]  r_hi [4];

    bpte_pkg::t_lane_bus r_b;
    bpte_pkg::t_lane_bus n_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va   <= i_bus.valid;
            r_dza  <= i_bus.dz;
            r_ovfa <= i_bus.ovf;
            r_sa   <= i_bus.s;
            for (int d = 0; d < 4; d++) begin
                r_acca[d] <= i_bus.acc[d];
                r_lo[d]   <= 56'(i_bus.acc[d][31:0]) * 56'(i_bus.s);
                r_hi[d]   <= 57'($signed(i_bus.acc[d][63:32])) * 57'($signed({1'b0, i_bus.s}));
            end
        end
    end

    // stage B: sum partials, round to the time scale, saturate, add coefficient
    always_comb begin
        logic signed [89:0] p;
        logic signed [89:0] r;
        logic signed [63:0] m;
        logic signed [64:0] sm;
        logic               ovf;
        ovf       = r_ovfa;
        n_b.valid = r_va;
        n_b.dz    = r_dza;
        n_b.s     = r_sa;
        for (int d = 0; d < 4; d++) begin
            p = (90'(r_hi[d]) <<< 32) + 90'($signed({1'b0, r_lo[d]}));
            r = (p + 90'(1 << (bpte_pkg::TIME_FRAC_BITS - 1))) >>> bpte_pkg::TIME_FRAC_BITS;
            if (r[89:63] == {27{r[63]}}) begin
                m = r[63:0];
            end else begin
                m = r[89] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                if (i_active[d]) ovf = 1'b1;
            end
            sm = 65'(m) + 65'(i_k[d]);
            if (!i_active[d]) begin
                n_b.acc[d] = r_acca[d];
            end else if (sm[64] != sm[63]) begin
                n_b.acc[d] = sm[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                ovf = 1'b1;
            end else begin
                n_b.acc[d] = sm[63:0];
            end
        end
        n_b.ovf = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_bus = r_b;

endmodule
`default_nettype wire

### sv/boundary_polynomial_trajectory_eval_core.sv
// Top level: polynomial trajectory evaluator with a row of Horner cells.
// Usage:
//   i_cfg writes the boundary registers (index 0..7); ready is always high.
//   Any write drops the coefficient cache; the builder then rebuilds the
//   six coefficients with one shared 32x32 multiplier (four partial
//   products a product) and a bit-serial divider (128 quotient bits).
//   i_sample.ready stays low until the build is done, except when duration
//   is zero (then each sample returns zeros with status 2 and no build is
//   needed).
//   Once built, one sample is taken per cycle while o_result is not
//   stalled. Each sample passes an input register, five two-stage Horner
//   cells (one step for each derivative lane still active) and an output
//   register, from which the result is presented on o_result.
//   A stalled o_result freezes the whole row and holds i_sample.ready low.
//   Reset (i_rst_n low, synchronous) empties the row, restores register
//   defaults and starts a build for the default configuration.
`timescale 1ns / 1ps
`default_nettype none
module boundary_polynomial_trajectory_eval_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    bpte_sample_if.sink      i_sample,
    bpte_cfg_if.sink         i_cfg,
    bpte_result_if.source    o_result
);

    typedef struct packed {
        logic               valid;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic signed [31:0] jrk;
        logic [1:0]         status;
    } t_out;

    bpte_pkg::t_build_st                          st;
    bpte_pkg::t_word [bpte_pkg::CACHE_N-1:0]      cache;
    bpte_pkg::t_lane_bus                          bus [bpte_pkg::NUM_CELLS+1];
    bpte_pkg::t_lane_bus                          r_s0;
    bpte_pkg::t_lane_bus                          n_s0;
    t_out                                         r_out;
    t_out                                         n_out;
    logic                                         adv;
    logic                                         in_acc;

    bpte_builder u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_st    (st),
        .o_cache (cache)
    );

    // row advances unless a finished result is held
    assign adv            = !r_out.valid || o_result.ready;
    assign i_sample.ready = adv && (st.valid || st.dur_zero);
    assign in_acc         = i_sample.valid && i_sample.ready;

    // input register: lanes start at their leading coefficient
    always_comb begin
        n_s0.valid = in_acc;
        n_s0.dz    = st.dur_zero;
        n_s0.ovf   = 1'b0;
        n_s0.s     = i_sample.sample_time;
        for (int d = 0; d < bpte_pkg::NUM_LANES; d++) begin
            n_s0.acc[d] = cache[bpte_pkg::cache_idx(d, 5)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (adv) begin
            r_s0 <= n_s0;
        end
    end

    assign bus[0] = r_s0;

    // row of Horner cells; cell j folds in coefficient 4-j
    for (genvar j = 0; j < bpte_pkg::NUM_CELLS; j++) begin : g_cell
        logic [3:0]             act;
        bpte_pkg::t_word [3:0]  kv;
        for (genvar d = 0; d < bpte_pkg::NUM_LANES; d++) begin : g_lane
            assign act[d] = ((4 - j) >= d);
            assign kv[d]  = ((4 - j) >= d) ? cache[bpte_pkg::cache_idx(d, 4 - j)] : '0;
        end
        bpte_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv),
            .i_active (act),
            .i_k      (kv),
            .i_bus    (bus[j]),
            .o_bus    (bus[j+1])
        );
    end

    // narrowing to the output format
    always_comb begin
        logic signed [64:0] v;
        logic signed [31:0] nv [4];
        logic               clip;
        clip = 1'b0;
        for (int d = 0; d < bpte_pkg::NUM_LANES; d++) begin
            v = (65'(bus[bpte_pkg::NUM_CELLS].acc[d]) + 65'(1 << (bpte_pkg::OUT_SHIFT - 1)))
                >>> bpte_pkg::OUT_SHIFT;
            if (v[64:31] == {34{v[31]}}) begin
                nv[d] = v[31:0];
            end else begin
                nv[d] = v[64] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
                clip  = 1'b1;
            end
        end
        n_out.valid = bus[bpte_pkg::NUM_CELLS].valid;
        if (bus[bpte_pkg::NUM_CELLS].dz) begin
            n_out.pos    = '0;
            n_out.vel    = '0;
            n_out.acc    = '0;
            n_out.jrk    = '0;
            n_out.status = bpte_pkg::ST_ZERO;
        end else begin
            n_out.pos    = nv[0];
            n_out.vel    = nv[1];
            n_out.acc    = nv[2];
            n_out.jrk    = nv[3];
            n_out.status = (clip || bus[bpte_pkg::NUM_CELLS].ovf || st.sat) ?
                           bpte_pkg::ST_SAT : bpte_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid        = r_out.valid;
    assign o_result.position_out = r_out.pos;
    assign o_result.velocity_out = r_out.vel;
    assign o_result.accel_out    = r_out.acc;
    assign o_result.jerk_out     = r_out.jrk;
    assign o_result.status       = r_out.status;

    // a sample only enters with a finished cache or a zero duration
    a_enter_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (st.valid || st.dur_zero))
        else $error("sample accepted without coefficients");

    // a register write invalidates the cache
    a_cfg_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> !st.valid)
        else $error("cache still valid after register write");

    // zero-duration results carry zero position and jerk values
    a_zero_vals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status == bpte_pkg::ST_ZERO) |->
        (o_result.position_out == 0 && o_result.jerk_out == 0))
        else $error("nonzero value with zero duration");

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the boundary polynomial trajectory evaluator.
`timescale 1ns / 1ps
`default_nettype none
module tb;

    localparam logic FIT_QUINTIC = 1'b0;
    localparam logic FIT_QUARTIC = 1'b1;
    localparam int   SETTLE      = 20;     // cycles waited once every expected point is in
    localparam int   ITEM_GOAL   = 1450;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic signed [31:0] jerk;
        logic [1:0]         status;
    } t_traj_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bpte_sample_if sample_ch();
    bpte_result_if result_ch();
    bpte_cfg_if    cfg_ch();

    boundary_polynomial_trajectory_eval_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .i_cfg    (cfg_ch.sink),
        .o_result (result_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: registers and coefficient cache
    logic               m_fit;
    bpte_pkg::t_word    m_x0, m_v0, m_a0, m_xT, m_vT, m_aT;
    logic [23:0]        m_dur;
    bpte_pkg::t_word    m_coef [6];
    bit                 m_coef_ok;
    bit                 m_coef_sat;
    bit                 m_ovf;

    t_traj_point        point_q[$];
    int                 errors = 0;
    int                 items_sent = 0;
    int                 points_checked = 0;
    int                 phases_run = 0;
    bit                 no_gaps = 1'b0;
    int                 hold_len = 0;

    // ---------------- fixed-point helpers ----------------
    function automatic bpte_pkg::t_word sat128(input logic signed [127:0] p);
        if (p[127:63] != {65{p[63]}}) begin
            m_ovf = 1'b1;
            return p[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return p[63:0];
    endfunction

    function automatic bpte_pkg::t_word mshift(input bpte_pkg::t_word a,
                                               input bpte_pkg::t_word b, input int s);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = pa * pb;
        if (s > 0) p = p + (128'sd1 <<< (s - 1));
        p = p >>> s;
        return sat128(p);
    endfunction

    function automatic bpte_pkg::t_word qdiv(input bpte_pkg::t_word num,
                                             input logic [63:0] den, input int s);
        logic [63:0]  m;
        logic [127:0] n, q;
        if (den == 0) begin
            m_ovf = 1'b1;
            return 0;
        end
        m = num[63] ? (~num + 64'd1) : num;
        n = {64'b0, m} << s;
        n = n + 128'(den >> 1);
        q = n / {64'b0, den};
        if (num[63]) q = -q;
        return sat128($signed(q));
    endfunction

    function automatic bpte_pkg::t_word sadd(input bpte_pkg::t_word a,
                                             input bpte_pkg::t_word b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return sat128(wa + wb);
    endfunction

    function automatic bpte_pkg::t_word ssub(input bpte_pkg::t_word a,
                                             input bpte_pkg::t_word b);
        logic signed [127:0] wa, wb;
        wa = a;
        wb = b;
        return sat128(wa - wb);
    endfunction

    function automatic bpte_pkg::t_word wmul(input bpte_pkg::t_word a,
                                             input bpte_pkg::t_word b);
        return mshift(a, b, bpte_pkg::COEF_FRAC_BITS);
    endfunction

    function automatic bpte_pkg::t_word div_by_dur(input bpte_pkg::t_word x,
                                                   input logic [63:0] tu, input int n);
        for (int i = 0; i < n; i++) x = qdiv(x, tu, bpte_pkg::COEF_FRAC_BITS);
        return x;
    endfunction

    // Closed-form boundary fit into the coefficient cache
    task automatic fit_coefficients();
        logic [63:0] tu;
        bpte_pkg::t_word tw, x0, v0, a0, xT, vT, aT, t2, dv, da;
        bpte_pkg::t_word h, dvt, dat2, half, k3, k4, k5, dat, n3, n4;
        tu = {40'b0, m_dur} << (bpte_pkg::COEF_FRAC_BITS - bpte_pkg::TIME_FRAC_BITS);
        tw = tu;
        m_ovf = 1'b0;
        x0 = mshift(m_x0, 64'sd1 <<< bpte_pkg::OUT_SHIFT, 0);
        v0 = mshift(m_v0, 64'sd1 <<< bpte_pkg::OUT_SHIFT, 0);
        a0 = mshift(m_a0, 64'sd1 <<< bpte_pkg::OUT_SHIFT, 0);
        xT = mshift(m_xT, 64'sd1 <<< bpte_pkg::OUT_SHIFT, 0);
        vT = mshift(m_vT, 64'sd1 <<< bpte_pkg::OUT_SHIFT, 0);
        aT = mshift(m_aT, 64'sd1 <<< bpte_pkg::OUT_SHIFT, 0);
        t2 = wmul(tw, tw);
        dv = ssub(ssub(vT, v0), wmul(a0, tw));
        da = ssub(aT, a0);
        m_coef[0] = x0;
        m_coef[1] = v0;
        m_coef[2] = mshift(a0, 1, 1);
        if (m_fit == FIT_QUINTIC) begin
            h = ssub(ssub(ssub(xT, x0), wmul(v0, tw)),
                     mshift(a0, t2, bpte_pkg::COEF_FRAC_BITS + 1));
            dvt = wmul(dv, tw);
            dat2 = wmul(da, t2);
            half = mshift(da, t2, bpte_pkg::COEF_FRAC_BITS + 1);
            k3 = sadd(ssub(mshift(h, 10, 0), mshift(dvt, 4, 0)), half);
            k4 = ssub(sadd(mshift(h, -15, 0), mshift(dvt, 7, 0)), dat2);
            k5 = sadd(ssub(mshift(h, 6, 0), mshift(dvt, 3, 0)), half);
            m_coef[3] = div_by_dur(k3, tu, 3);
            m_coef[4] = div_by_dur(k4, tu, 4);
            m_coef[5] = div_by_dur(k5, tu, 5);
        end else begin
            dat = wmul(da, tw);
            n4 = ssub(dat, mshift(dv, 2, 0));
            n3 = ssub(mshift(dv, 3, 0), dat);
            m_coef[4] = mshift(div_by_dur(n4, tu, 3), 1, 2);
            m_coef[3] = qdiv(div_by_dur(n3, tu, 2), 3, 0);
            m_coef[5] = 0;
        end
        m_coef_sat = m_ovf;
        m_coef_ok = 1'b1;
    endtask

    // d-th derivative by Horner's rule, narrowed to the output format
    function automatic logic signed [31:0] derivative_at(input int d, input bpte_pkg::t_word tw);
        bpte_pkg::t_word k [6];
        bpte_pkg::t_word acc, f;
        int n;
        n = 6 - d;
        for (int i = 0; i < n; i++) begin
            f = 1;
            for (int j = 1; j <= d; j++) f = f * 64'(i + j);
            k[i] = mshift(m_coef[i + d], f, 0);
        end
        acc = k[n - 1];
        for (int i = n - 2; i >= 0; i--) acc = sadd(wmul(acc, tw), k[i]);
        acc = mshift(acc, 1, bpte_pkg::OUT_SHIFT);
        if (acc > 64'sd2147483647) begin
            m_ovf = 1'b1;
            acc = 64'sd2147483647;
        end
        if (acc < -64'sd2147483648) begin
            m_ovf = 1'b1;
            acc = -64'sd2147483648;
        end
        return acc[31:0];
    endfunction

    task automatic predict_point(input logic [23:0] t, output t_traj_point r);
        bpte_pkg::t_word tw;
        if (m_dur == 0) begin
            r = '{0, 0, 0, 0, bpte_pkg::ST_ZERO};
            return;
        end
        if (!m_coef_ok) fit_coefficients();
        m_ovf = m_coef_sat;
        tw = {40'b0, t} << (bpte_pkg::COEF_FRAC_BITS - bpte_pkg::TIME_FRAC_BITS);
        r.pos = derivative_at(0, tw);
        r.vel = derivative_at(1, tw);
        r.acc = derivative_at(2, tw);
        r.jerk = derivative_at(3, tw);
        r.status = m_ovf ? bpte_pkg::ST_SAT : bpte_pkg::ST_OK;
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            bpte_pkg::CFG_FIT_MODE:  m_fit = val[0];
            bpte_pkg::CFG_START_POS: m_x0 = $signed(val);
            bpte_pkg::CFG_START_VEL: m_v0 = $signed(val);
            bpte_pkg::CFG_START_ACC: m_a0 = $signed(val);
            bpte_pkg::CFG_END_POS:   m_xT = $signed(val);
            bpte_pkg::CFG_END_VEL:   m_vT = $signed(val);
            bpte_pkg::CFG_END_ACC:   m_aT = $signed(val);
            bpte_pkg::CFG_DURATION:  m_dur = val[23:0];
            default: ;
        endcase
        m_coef_ok = 1'b0;
    endtask

    // ---------------- channel drivers ----------------
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(input logic [23:0] t);
        int gap;
        t_traj_point r;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample_time <= t;
        do @(posedge i_clk); while (!sample_ch.ready);
        predict_point(t, r);
        point_q.push_back(r);
        items_sent++;
    endtask

    task automatic end_samples();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expected point is in, then let the row drain
    task automatic drain();
        end_samples();
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, val);
    endtask

    task automatic load_profile(input logic fit, input logic [31:0] x0, input logic [31:0] v0,
                                input logic [31:0] a0, input logic [31:0] xT,
                                input logic [31:0] vT, input logic [31:0] aT,
                                input logic [23:0] dur);
        write_reg(bpte_pkg::CFG_FIT_MODE, {31'b0, fit});
        write_reg(bpte_pkg::CFG_START_POS, x0);
        write_reg(bpte_pkg::CFG_START_VEL, v0);
        write_reg(bpte_pkg::CFG_START_ACC, a0);
        write_reg(bpte_pkg::CFG_END_POS, xT);
        write_reg(bpte_pkg::CFG_END_VEL, vT);
        write_reg(bpte_pkg::CFG_END_ACC, aT);
        write_reg(bpte_pkg::CFG_DURATION, {8'b0, dur});
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        phases_run++;
    endtask

    // ---------------- result side ----------------
    initial begin
        int stall;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                result_ch.ready <= 1'b0;
                hold_len--;
            end else if (stall > 0) begin
                result_ch.ready <= 1'b0;
                stall--;
            end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
                result_ch.ready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(0, 2);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_traj_point e;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (point_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = point_q.pop_front();
                points_checked++;
                if (result_ch.position_out !== e.pos) begin
                    $error("position_out exp %0d got %0d", e.pos, result_ch.position_out);
                    errors++;
                end
                if (result_ch.velocity_out !== e.vel) begin
                    $error("velocity_out exp %0d got %0d", e.vel, result_ch.velocity_out);
                    errors++;
                end
                if (result_ch.accel_out !== e.acc) begin
                    $error("accel_out exp %0d got %0d", e.acc, result_ch.accel_out);
                    errors++;
                end
                if (result_ch.jerk_out !== e.jerk) begin
                    $error("jerk_out exp %0d got %0d", e.jerk, result_ch.jerk_out);
                    errors++;
                end
                if (result_ch.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, result_ch.status);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    function automatic logic [31:0] rand_boundary();
        int r;
        r = $urandom_range(0, 11);
        if (r < 7) return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        if (r < 9) return $urandom;
        if (r == 9) return 32'h7FFF_FFFF;
        if (r == 10) return 32'h8000_0000;
        return 32'h0;
    endfunction

    function automatic logic [23:0] rand_duration();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15) return 24'($urandom_range(24'h0_4000, 24'h3_0000));
        if (r == 15) return 24'h0;
        if (r == 16) return 24'h1;
        if (r == 17) return 24'hFF_FFFF;
        return 24'($urandom_range(1, 24'hFF_FFFF));
    endfunction

    function automatic logic [23:0] rand_time();
        int lim;
        lim = int'(m_dur) + int'(m_dur >> 3);
        if (lim > 24'hFF_FFFF) lim = 24'hFF_FFFF;
        if (m_dur != 0 && $urandom_range(0, 9) < 8)
            return 24'($urandom_range(0, lim));
        return 24'($urandom_range(0, 24'hFF_FFFF));
    endfunction

    // Defaults after reset: everything zero, duration one second
    task automatic test_reset_defaults();
        send_sample(24'h0);
        send_sample(24'h1_0000);
        send_sample(24'hFF_FFFF);
        drain();
    endtask

    // Start/end of the trajectory, extremes of time, both fit modes
    task automatic test_directed_profiles();
        load_profile(FIT_QUINTIC, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000,
                     32'h000A_0000, 32'h0, 32'h0, 24'h2_0000);
        send_sample(24'h0);
        send_sample(24'h1);
        send_sample(24'h1_0000);
        send_sample(24'h2_0000);
        send_sample(24'h2_8000);
        send_sample(24'hFF_FFFF);
        drain();
        load_profile(FIT_QUARTIC, 32'hFFF0_0000, 32'h0003_0000, 32'h0,
                     32'h7FFF_FFFF, 32'hFFFE_0000, 32'h0001_8000, 24'h1_8000);
        send_sample(24'h0);
        send_sample(24'h1_8000);
        send_sample(24'h80_0000);
        drain();
        // saturating boundaries and the shortest and longest duration
        load_profile(FIT_QUINTIC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h1);
        send_sample(24'h0);
        send_sample(24'h1);
        drain();
        load_profile(FIT_QUARTIC, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
        send_sample(24'h0);
        send_sample(24'hFF_FFFF);
        drain();
        // zero duration: flagged, no fit
        load_profile(FIT_QUINTIC, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 24'h0);
        send_sample(24'h0);
        send_sample(24'hFF_FFFF);
        send_sample(24'h1234);
        drain();
    endtask

    // Long receiver hold-off while samples keep coming, then a full pause
    task automatic test_backpressure();
        load_profile(FIT_QUINTIC, rand_boundary(), rand_boundary(), rand_boundary(),
                     rand_boundary(), rand_boundary(), rand_boundary(), 24'h1_0000);
        no_gaps = 1'b1;
        send_sample(rand_time());
        hold_len = 200;
        repeat (60) send_sample(rand_time());
        no_gaps = 1'b0;
        end_samples();
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (40) send_sample(rand_time());
        drain();
    endtask

    task automatic test_random_profiles();
        int n;
        while (items_sent < ITEM_GOAL) begin
            load_profile(logic'($urandom_range(0, 1)), rand_boundary(), rand_boundary(),
                         rand_boundary(), rand_boundary(), rand_boundary(), rand_boundary(),
                         rand_duration());
            no_gaps = ($urandom_range(0, 4) == 0);
            n = $urandom_range(60, 150);
            repeat (n) send_sample(rand_time());
            no_gaps = 1'b0;
            drain();
        end
    endtask

    // ---------------- sequence ----------------
    initial begin
        sample_ch.valid <= 1'b0;
        sample_ch.sample_time <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= bpte_pkg::CFG_FIT_MODE;
        cfg_ch.data <= '0;
        m_fit = FIT_QUINTIC;
        m_x0 = 0; m_v0 = 0; m_a0 = 0; m_xT = 0; m_vT = 0; m_aT = 0;
        m_dur = 24'h1_0000;
        for (int i = 0; i < 6; i++) m_coef[i] = 0;
        m_coef_ok = 1'b0;
        m_coef_sat = 1'b0;
        m_ovf = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_profiles();
        test_backpressure();
        test_random_profiles();

        $display("Covered %0d samples over %0d boundary profiles, %0d results checked.",
                 items_sent, phases_run, points_checked);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("Timed out with %0d results outstanding.", point_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
